@@ rtl/fir_decimate_correlator_peak_macros.svh @@
// Assertion macros; the using scope provides clk and rst_n.
`ifndef FIR_DECIMATE_CORRELATOR_PEAK_MACROS_SVH
`define FIR_DECIMATE_CORRELATOR_PEAK_MACROS_SVH

`define FDCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define FDCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fdcp_pkg.sv @@
package fdcp_pkg;

  localparam int VALUE_BITS  = 16;
  localparam int INDEX_BITS  = 5;
  localparam int SELECT_BITS = 2;
  localparam int CODE_NUM_BITS = 2;
  localparam int ACC_BITS    = 32;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_TAP    = 2'd1,
    REQ_CODE   = 2'd2
  } req_t;

  typedef struct packed {
    logic [1:0]                    req_type;
    logic [INDEX_BITS-1:0]         tap_index;
    logic [SELECT_BITS-1:0]        code_select;
    logic signed [VALUE_BITS-1:0]  value;
    logic                          frame_end;
  } in_t;

  typedef struct packed {
    logic [CODE_NUM_BITS-1:0]      code_number;
    logic signed [ACC_BITS-1:0]    peak;
    logic                          last_peak;
  } out_t;

  typedef struct packed {
    logic valid;
    logic code;
    logic zero;
    logic first;
    logic last;
    logic done;
  } tok_t;

  typedef struct packed {
    logic hist;
    logic tap;
    logic code;
    logic kept;
  } we_t;

endpackage

@@ rtl/fdcp_store.sv @@
module fdcp_store #(
  parameter int TAP_COUNT   = 16,
  parameter int CODE_TAPS   = 32,
  parameter int CODE_COUNT  = 4,
  parameter int SAMPLE_BITS = 16,
  localparam int NA = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1,
  localparam int TA = (CODE_TAPS > 1) ? $clog2(CODE_TAPS) : 1,
  localparam int CD = CODE_COUNT * CODE_TAPS,
  localparam int CA = (CD > 1) ? $clog2(CD) : 1
) (
  input  logic                            clk,
  input  fdcp_pkg::we_t                   we,
  input  logic [fdcp_pkg::VALUE_BITS-1:0] load_data,
  input  logic [SAMPLE_BITS-1:0]          kept_wdata,
  input  logic [NA-1:0]                   hist_waddr,
  input  logic [NA-1:0]                   hist_raddr,
  input  logic [NA-1:0]                   tap_waddr,
  input  logic [NA-1:0]                   tap_raddr,
  input  logic [TA-1:0]                   kept_waddr,
  input  logic [TA-1:0]                   kept_raddr,
  input  logic [CA-1:0]                   code_waddr,
  input  logic [CA-1:0]                   code_raddr,
  output logic [fdcp_pkg::VALUE_BITS-1:0] hist_q,
  output logic [fdcp_pkg::VALUE_BITS-1:0] tap_q,
  output logic [SAMPLE_BITS-1:0]          kept_q,
  output logic [fdcp_pkg::VALUE_BITS-1:0] code_q
);

  logic [fdcp_pkg::VALUE_BITS-1:0] hist_mem [TAP_COUNT];
  logic [fdcp_pkg::VALUE_BITS-1:0] tap_mem  [TAP_COUNT];
  logic [SAMPLE_BITS-1:0]          kept_mem [CODE_TAPS];
  logic [fdcp_pkg::VALUE_BITS-1:0] code_mem [CD];

  always_ff @(posedge clk) begin
    if (we.hist) begin
      hist_mem[hist_waddr] <= load_data;
    end
    hist_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.tap) begin
      tap_mem[tap_waddr] <= load_data;
    end
    tap_q <= tap_mem[tap_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.kept) begin
      kept_mem[kept_waddr] <= kept_wdata;
    end
    kept_q <= kept_mem[kept_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.code) begin
      code_mem[code_waddr] <= load_data;
    end
    code_q <= code_mem[code_raddr];
  end

endmodule

@@ rtl/fdcp_mac.sv @@
module fdcp_mac #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fdcp_pkg::tok_t                         issue_tok,
  input  logic [fdcp_pkg::VALUE_BITS-1:0]        hist_q,
  input  logic [fdcp_pkg::VALUE_BITS-1:0]        tap_q,
  input  logic [SAMPLE_BITS-1:0]                 kept_q,
  input  logic [fdcp_pkg::VALUE_BITS-1:0]        code_q,
  output fdcp_pkg::tok_t                         res_tok,
  output logic signed [fdcp_pkg::ACC_BITS-1:0]   res_sum
);

  fdcp_pkg::tok_t                       tok1_r;
  fdcp_pkg::tok_t                       tok2_r;
  logic signed [fdcp_pkg::ACC_BITS-1:0] op_a;
  logic signed [fdcp_pkg::ACC_BITS-1:0] op_b;
  logic signed [fdcp_pkg::ACC_BITS-1:0] prod;
  logic signed [fdcp_pkg::ACC_BITS-1:0] prod_r;
  logic signed [fdcp_pkg::ACC_BITS-1:0] acc_r;
  logic signed [fdcp_pkg::ACC_BITS-1:0] acc_base;

  always_comb begin
    if (tok1_r.code) begin
      op_a = fdcp_pkg::ACC_BITS'(signed'(kept_q));
      op_b = fdcp_pkg::ACC_BITS'(signed'(code_q));
    end else begin
      op_a = fdcp_pkg::ACC_BITS'(signed'(hist_q));
      op_b = fdcp_pkg::ACC_BITS'(signed'(tap_q));
    end
    if (tok1_r.zero) begin
      op_a = '0;
    end
  end

  assign prod     = op_a * op_b;
  assign acc_base = tok2_r.first ? '0 : acc_r;
  assign res_sum  = acc_base + prod_r;
  assign res_tok  = tok2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r <= '0;
      tok2_r <= '0;
    end else begin
      tok1_r <= issue_tok;
      tok2_r <= tok1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (tok2_r.valid) begin
      acc_r <= res_sum;
    end
  end

endmodule

@@ rtl/fir_decimate_correlator_peak.sv @@
// Channel   Direction  Beat                 Handshake
// in_       input      sample or load item  in_valid / in_ready
// out_      output     one peak per code    out_valid / out_ready
//
// Load items are taken in ST_IDLE and leave it there. A sample runs its filter taps through one
// shared multiply-accumulate; a kept sample (every second one) then runs each code's taps too.
// A frame end then moves the peaks, one per code, into the output register.
// rst_n is synchronous; history counts, peaks and keep phase clear, tap and code stores do not.
// in_ready is low while a sample is in work; out_ready low holds the output beat.
module fir_decimate_correlator_peak #(
  parameter int TAP_COUNT   = 16,
  parameter int CODE_TAPS   = 32,
  parameter int CODE_COUNT  = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  fdcp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output fdcp_pkg::out_t out_data
);

  localparam int NA = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int NC = $clog2(TAP_COUNT + 1);
  localparam int TA = (CODE_TAPS > 1) ? $clog2(CODE_TAPS) : 1;
  localparam int KC = $clog2(CODE_TAPS + 1);
  localparam int CC = (CODE_COUNT > 1) ? $clog2(CODE_COUNT) : 1;
  localparam int CD = CODE_COUNT * CODE_TAPS;
  localparam int CA = (CD > 1) ? $clog2(CD) : 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FILT  = 6'b000010,
    ST_FWAIT = 6'b000100,
    ST_CORR  = 6'b001000,
    ST_CWAIT = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [NA-1:0]        fwp_r, fwp_nxt, fwp_inc;
  logic [NA-1:0]        fra_r, fra_nxt;
  logic [NC-1:0]        fcnt_r, fcnt_nxt;
  logic [NA-1:0]        fi_r, fi_nxt;
  logic [TA-1:0]        kwp_r, kwp_nxt, kwp_inc;
  logic [TA-1:0]        kra_r, kra_nxt;
  logic [KC-1:0]        kcnt_r, kcnt_nxt;
  logic [TA-1:0]        ki_r, ki_nxt;
  logic [CC-1:0]        kc_r, kc_nxt;
  logic [CA-1:0]        cra_r, cra_nxt;
  logic                 keep_r, keep_nxt;
  logic                 fend_r, fend_nxt;
  logic [CC-1:0]        ec_r, ec_nxt;
  logic signed [fdcp_pkg::ACC_BITS-1:0] peak_r   [CODE_COUNT];
  logic signed [fdcp_pkg::ACC_BITS-1:0] peak_nxt [CODE_COUNT];
  logic                 out_valid_r, out_valid_nxt;
  fdcp_pkg::out_t       out_data_r, out_data_nxt;

  fdcp_pkg::we_t        we;
  fdcp_pkg::tok_t       issue_tok;
  fdcp_pkg::tok_t       res_tok;
  logic signed [fdcp_pkg::ACC_BITS-1:0] res_sum;
  logic [NA-1:0]        tap_waddr, tap_raddr;
  logic [CA-1:0]        code_waddr;
  logic [TA-1:0]        kept_age;
  logic [fdcp_pkg::VALUE_BITS-1:0] hist_q, tap_q, code_q;
  logic [SAMPLE_BITS-1:0] kept_q;
  logic                 fi_last, ki_last;

  assign fwp_inc   = (fwp_r == NA'(TAP_COUNT - 1)) ? '0 : fwp_r + 1'b1;
  assign kwp_inc   = (kwp_r == TA'(CODE_TAPS - 1)) ? '0 : kwp_r + 1'b1;
  assign tap_waddr = NA'(in_data.tap_index);
  assign tap_raddr = NA'(TAP_COUNT - 1) - fi_r;
  assign kept_age  = TA'(CODE_TAPS - 1) - ki_r;
  assign code_waddr = CA'(int'(in_data.code_select) * CODE_TAPS + int'(in_data.tap_index));
  assign fi_last   = (fi_r == NA'(TAP_COUNT - 1));
  assign ki_last   = (ki_r == TA'(CODE_TAPS - 1));

  always_comb begin
    state_nxt     = state_r;
    fwp_nxt       = fwp_r;
    fra_nxt       = fra_r;
    fcnt_nxt      = fcnt_r;
    fi_nxt        = fi_r;
    kwp_nxt       = kwp_r;
    kra_nxt       = kra_r;
    kcnt_nxt      = kcnt_r;
    ki_nxt        = ki_r;
    kc_nxt        = kc_r;
    cra_nxt       = cra_r;
    keep_nxt      = keep_r;
    fend_nxt      = fend_r;
    ec_nxt        = ec_r;
    peak_nxt      = peak_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    we            = '0;
    issue_tok     = '0;

    // rotate peaks as each code's correlation completes
    if (res_tok.valid && res_tok.code && res_tok.last) begin
      for (int k = 0; k < CODE_COUNT - 1; k++) begin
        peak_nxt[k] = peak_r[k + 1];
      end
      peak_nxt[CODE_COUNT - 1] = (res_sum > peak_r[0]) ? res_sum : peak_r[0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.req_type)
            fdcp_pkg::REQ_SAMPLE: begin
              we.hist   = 1'b1;
              fwp_nxt   = fwp_inc;
              fra_nxt   = fwp_inc;
              fcnt_nxt  = (fcnt_r == NC'(TAP_COUNT)) ? fcnt_r : fcnt_r + 1'b1;
              fi_nxt    = '0;
              fend_nxt  = in_data.frame_end;
              state_nxt = ST_FILT;
            end
            fdcp_pkg::REQ_TAP: begin
              we.tap = (int'(in_data.tap_index) < TAP_COUNT);
            end
            fdcp_pkg::REQ_CODE: begin
              we.code = (int'(in_data.tap_index) < CODE_TAPS) &&
                        (int'(in_data.code_select) < CODE_COUNT);
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILT: begin
        issue_tok.valid = 1'b1;
        issue_tok.zero  = ((NC + 1)'(tap_raddr) >= (NC + 1)'(fcnt_r));
        issue_tok.first = (fi_r == '0);
        issue_tok.last  = fi_last;
        fra_nxt = (fra_r == NA'(TAP_COUNT - 1)) ? '0 : fra_r + 1'b1;
        fi_nxt  = fi_r + 1'b1;
        if (fi_last) begin
          state_nxt = ST_FWAIT;
        end
      end
      ST_FWAIT: begin
        if (res_tok.valid && res_tok.last) begin
          keep_nxt = ~keep_r;
          if (!keep_r) begin
            we.kept   = 1'b1;
            kwp_nxt   = kwp_inc;
            kra_nxt   = kwp_inc;
            kcnt_nxt  = (kcnt_r == KC'(CODE_TAPS)) ? kcnt_r : kcnt_r + 1'b1;
            ki_nxt    = '0;
            kc_nxt    = '0;
            cra_nxt   = '0;
            state_nxt = ST_CORR;
          end else begin
            state_nxt = fend_r ? ST_EMIT : ST_IDLE;
          end
        end
      end
      ST_CORR: begin
        issue_tok.valid = 1'b1;
        issue_tok.code  = 1'b1;
        issue_tok.zero  = ((KC + 1)'(kept_age) >= (KC + 1)'(kcnt_r));
        issue_tok.first = (ki_r == '0);
        issue_tok.last  = ki_last;
        issue_tok.done  = ki_last && (kc_r == CC'(CODE_COUNT - 1));
        kra_nxt = (kra_r == TA'(CODE_TAPS - 1)) ? '0 : kra_r + 1'b1;
        cra_nxt = cra_r + 1'b1;
        if (ki_last) begin
          ki_nxt = '0;
          kc_nxt = kc_r + 1'b1;
        end else begin
          ki_nxt = ki_r + 1'b1;
        end
        if (issue_tok.done) begin
          state_nxt = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        if (res_tok.valid && res_tok.done) begin
          state_nxt = fend_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.code_number = fdcp_pkg::CODE_NUM_BITS'(ec_r);
          out_data_nxt.peak        = peak_r[0];
          out_data_nxt.last_peak   = (ec_r == CC'(CODE_COUNT - 1));
          for (int k = 0; k < CODE_COUNT - 1; k++) begin
            peak_nxt[k] = peak_r[k + 1];
          end
          peak_nxt[CODE_COUNT - 1] = '0;
          ec_nxt = ec_r + 1'b1;
          if (ec_r == CC'(CODE_COUNT - 1)) begin
            ec_nxt    = '0;
            fcnt_nxt  = '0;
            kcnt_nxt  = '0;
            keep_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fwp_r       <= '0;
      fra_r       <= '0;
      fcnt_r      <= '0;
      fi_r        <= '0;
      kwp_r       <= '0;
      kra_r       <= '0;
      kcnt_r      <= '0;
      ki_r        <= '0;
      kc_r        <= '0;
      cra_r       <= '0;
      keep_r      <= 1'b0;
      fend_r      <= 1'b0;
      ec_r        <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < CODE_COUNT; k++) begin
        peak_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      fwp_r       <= fwp_nxt;
      fra_r       <= fra_nxt;
      fcnt_r      <= fcnt_nxt;
      fi_r        <= fi_nxt;
      kwp_r       <= kwp_nxt;
      kra_r       <= kra_nxt;
      kcnt_r      <= kcnt_nxt;
      ki_r        <= ki_nxt;
      kc_r        <= kc_nxt;
      cra_r       <= cra_nxt;
      keep_r      <= keep_nxt;
      fend_r      <= fend_nxt;
      ec_r        <= ec_nxt;
      out_valid_r <= out_valid_nxt;
      peak_r      <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fdcp_store #(
    .TAP_COUNT   (TAP_COUNT),
    .CODE_TAPS   (CODE_TAPS),
    .CODE_COUNT  (CODE_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk        (clk),
    .we         (we),
    .load_data  (in_data.value),
    .kept_wdata (res_sum[SAMPLE_BITS-1:0]),
    .hist_waddr (fwp_r),
    .hist_raddr (fra_r),
    .tap_waddr  (tap_waddr),
    .tap_raddr  (tap_raddr),
    .kept_waddr (kwp_r),
    .kept_raddr (kra_r),
    .code_waddr (code_waddr),
    .code_raddr (cra_r),
    .hist_q     (hist_q),
    .tap_q      (tap_q),
    .kept_q     (kept_q),
    .code_q     (code_q)
  );

  fdcp_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue_tok (issue_tok),
    .hist_q    (hist_q),
    .tap_q     (tap_q),
    .kept_q    (kept_q),
    .code_q    (code_q),
    .res_tok   (res_tok),
    .res_sum   (res_sum)
  );

endmodule

@@ rtl/fdcp_chk.sv @@
`include "fir_decimate_correlator_peak_macros.svh"

module fdcp_chk #(
  parameter int CODE_COUNT = 4
) (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input fdcp_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input fdcp_pkg::out_t out_data
);

  localparam int CC = (CODE_COUNT > 1) ? $clog2(CODE_COUNT) : 1;

  logic [CC-1:0] exp_r;
  logic          out_beat;
  logic          stall;
  logic          code_ok;
  logic          last_ok;
  logic          peak_pos;
  logic          sample_beat;

  assign out_beat    = out_valid && out_ready;
  assign stall       = out_valid && !out_ready;
  assign code_ok     = (out_data.code_number == fdcp_pkg::CODE_NUM_BITS'(exp_r));
  assign last_ok     = (out_data.last_peak == (exp_r == CC'(CODE_COUNT - 1)));
  assign peak_pos    = !out_data.peak[fdcp_pkg::ACC_BITS-1];
  assign sample_beat = in_valid && in_ready && (in_data.req_type == fdcp_pkg::REQ_SAMPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0;
    end else if (out_beat) begin
      exp_r <= (exp_r == CC'(CODE_COUNT - 1)) ? '0 : exp_r + 1'b1;
    end
  end

  `FDCP_ASSERT_NEXT(a_out_hold, stall, out_valid && $stable(out_data), "beat changed in stall")
  `FDCP_ASSERT_NOW(a_code_order, out_beat, code_ok, "peak out of code order")
  `FDCP_ASSERT_NOW(a_last_flag, out_beat, last_ok, "last_peak misplaced")
  `FDCP_ASSERT_NOW(a_peak_sign, out_valid, peak_pos, "peak below zero")
  `FDCP_ASSERT_NEXT(a_busy, sample_beat, !in_ready, "ready during sample work")

endmodule

bind fir_decimate_correlator_peak fdcp_chk #(
  .CODE_COUNT (CODE_COUNT)
) u_fdcp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int TAPS         = 16;
  localparam int CODE_LEN     = 32;
  localparam int CODES        = 4;
  localparam int IDLE_PCT     = 14;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [1:0] REQ_NONE = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  fdcp_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  fdcp_pkg::out_t out_data;

  fir_decimate_correlator_peak u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  logic signed [15:0] filt_hist [TAPS];
  logic signed [15:0] coef [TAPS];
  logic signed [15:0] code_word [CODES][CODE_LEN];
  logic signed [15:0] kept_hist [CODE_LEN];
  logic signed [31:0] peak_hold [CODES];
  bit   keep_odd;

  fdcp_pkg::out_t expected_peaks [$];
  fdcp_pkg::out_t want_peak;
  int   errors = 0;
  int   beats_sent = 0;
  int   frames_sent = 0;
  int   peaks_checked = 0;
  int   cycle_count = 0;
  bit   in_idle_en = 1'b1;
  bit   out_idle_en = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic clear_frame_state();
    foreach (filt_hist[i]) filt_hist[i] = '0;
    foreach (kept_hist[i]) kept_hist[i] = '0;
    foreach (peak_hold[i]) peak_hold[i] = '0;
    keep_odd = 1'b0;
  endtask

  task automatic predict_peaks(input fdcp_pkg::in_t item);
    logic signed [47:0] fir_sum;
    logic signed [15:0] filtered;
    logic signed [31:0] corr;
    fdcp_pkg::out_t     res;
    case (item.req_type)
      fdcp_pkg::REQ_TAP: begin
        if (item.tap_index < TAPS) coef[item.tap_index] = item.value;
      end
      fdcp_pkg::REQ_CODE: begin
        if (item.tap_index < CODE_LEN && item.code_select < CODES)
          code_word[item.code_select][item.tap_index] = item.value;
      end
      fdcp_pkg::REQ_SAMPLE: begin
        for (int i = TAPS - 1; i > 0; i--) filt_hist[i] = filt_hist[i-1];
        filt_hist[0] = item.value;
        fir_sum = '0;
        for (int i = 0; i < TAPS; i++) fir_sum += filt_hist[i] * coef[i];
        filtered = fir_sum[15:0];
        if (!keep_odd) begin
          for (int i = CODE_LEN - 1; i > 0; i--) kept_hist[i] = kept_hist[i-1];
          kept_hist[0] = filtered;
          for (int c = 0; c < CODES; c++) begin
            corr = '0;
            for (int i = 0; i < CODE_LEN; i++)
              corr += kept_hist[CODE_LEN-1-i] * code_word[c][i];
            if (corr > peak_hold[c]) peak_hold[c] = corr;
          end
        end
        keep_odd = ~keep_odd;
        if (item.frame_end) begin
          for (int c = 0; c < CODES; c++) begin
            res.code_number = c[1:0];
            res.peak        = peak_hold[c];
            res.last_peak   = (c == CODES - 1);
            expected_peaks.push_back(res);
          end
          frames_sent++;
          clear_frame_state();
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] rand_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return r[15:0];
    endcase
  endfunction

  function automatic fdcp_pkg::in_t make_item(input logic [1:0] kind, input int idx,
                                              input int sel, input logic signed [15:0] val,
                                              input bit fin);
    fdcp_pkg::in_t item;
    item.req_type    = kind;
    item.tap_index   = idx[4:0];
    item.code_select = sel[1:0];
    item.value       = val;
    item.frame_end   = fin;
    return item;
  endfunction

  // Enter and leave at a falling edge; valid stays high for a back-to-back beat.
  task automatic send_item(input fdcp_pkg::in_t item);
    if (in_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_peaks(item);
    beats_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= !(out_idle_en && $urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_peaks.size() == 0) begin
        errors++;
        $display("%0t: unexpected peak beat: code %0d peak %0d last %0d", $time,
                 out_data.code_number, out_data.peak, out_data.last_peak);
      end else begin
        want_peak = expected_peaks.pop_front();
        peaks_checked++;
        if (out_data !== want_peak) begin
          errors++;
          $display("%0t: peak mismatch: expected code %0d peak %0d last %0d,", $time,
                   want_peak.code_number, want_peak.peak, want_peak.last_peak);
          $display("%0t:                got code %0d peak %0d last %0d", $time,
                   out_data.code_number, out_data.peak, out_data.last_peak);
        end
      end
    end
  end

  task automatic test_load_stores();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    for (int i = 0; i < TAPS; i++)
      send_item(make_item(fdcp_pkg::REQ_TAP, i, $urandom_range(3), rand_value(),
                          $urandom_range(1)));
    for (int c = 0; c < CODES; c++)
      for (int i = 0; i < CODE_LEN; i++)
        send_item(make_item(fdcp_pkg::REQ_CODE, i, c, rand_value(), $urandom_range(1)));
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  task automatic test_ignored_items();
    send_item(make_item(REQ_NONE, 31, 3, 16'sh7fff, 1'b1));
    send_item(make_item(REQ_NONE, 0, 0, 16'sh8000, 1'b0));
    send_item(make_item(fdcp_pkg::REQ_TAP, 31, 3, 16'sh8000, 1'b1));
    send_item(make_item(fdcp_pkg::REQ_TAP, TAPS, 0, 16'sh7fff, 1'b0));
    send_item(make_item(fdcp_pkg::REQ_CODE, 31, 3, 16'sh7fff, 1'b1));
    send_item(make_item(fdcp_pkg::REQ_CODE, 0, 0, 16'sh8000, 1'b1));
  endtask

  task automatic test_sample_extremes();
    send_item(make_item(fdcp_pkg::REQ_SAMPLE, 0, 0, 16'sh8000, 1'b1));
    send_item(make_item(fdcp_pkg::REQ_SAMPLE, 31, 3, 16'sh7fff, 1'b0));
    send_item(make_item(fdcp_pkg::REQ_SAMPLE, 0, 0, 16'sh8000, 1'b0));
    send_item(make_item(fdcp_pkg::REQ_SAMPLE, 0, 0, 16'sh0000, 1'b0));
    send_item(make_item(fdcp_pkg::REQ_SAMPLE, 0, 0, -16'sd1, 1'b0));
    send_item(make_item(fdcp_pkg::REQ_SAMPLE, 0, 0, 16'sh7fff, 1'b1));
    send_item(make_item(fdcp_pkg::REQ_TAP, 0, 0, 16'sh7fff, 1'b0));
    send_item(make_item(fdcp_pkg::REQ_SAMPLE, 0, 0, 16'sh7fff, 1'b0));
    send_item(make_item(fdcp_pkg::REQ_SAMPLE, 0, 0, 16'sh7fff, 1'b1));
  endtask

  task automatic send_noise(inout int sent);
    case ($urandom_range(3))
      0: begin
        send_item(make_item(fdcp_pkg::REQ_TAP, $urandom_range(TAPS - 1), $urandom_range(3),
                            rand_value(), $urandom_range(1)));
        sent++;
      end
      1: begin
        send_item(make_item(fdcp_pkg::REQ_CODE, $urandom_range(31), $urandom_range(3),
                            rand_value(), $urandom_range(1)));
        sent++;
      end
      2: send_item(make_item(fdcp_pkg::REQ_TAP, $urandom_range(31, TAPS), $urandom_range(3),
                             rand_value(), $urandom_range(1)));
      default: send_item(make_item(REQ_NONE, $urandom_range(31), $urandom_range(3),
                                   rand_value(), $urandom_range(1)));
    endcase
  endtask

  task automatic test_random_frames(input int goal, input bit idle);
    int sent;
    int len;
    in_idle_en  = idle;
    out_idle_en = idle;
    sent = 0;
    while (sent < goal) begin
      if ($urandom_range(99) < 30) send_noise(sent);
      len = ($urandom_range(5) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        send_item(make_item(fdcp_pkg::REQ_SAMPLE, $urandom_range(31), $urandom_range(3),
                            rand_value(), k == len - 1));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    clear_frame_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_load_stores();
    test_ignored_items();
    test_sample_extremes();
    test_random_frames(6, 1'b1);
    test_random_frames(3, 1'b0);
    test_random_frames(3, 1'b1);
    in_valid <= 1'b0;
    while (expected_peaks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d input beats in %0d frames,", beats_sent, frames_sent);
    $display("with tap and code loads, ignored items and %0d peak beats checked (%0d bad).",
             peaks_checked, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ fir_decimate_correlator_peak.f @@
+incdir+rtl
rtl/fdcp_pkg.sv
rtl/fdcp_store.sv
rtl/fdcp_mac.sv
rtl/fir_decimate_correlator_peak.sv
rtl/fdcp_chk.sv
tb/sv/tb_top.sv
